/* design/cocp_pkg.sv */
// ----------------------------------------------------------------------------
// cocp_pkg
// Shared types and constants of the current offset, Clarke and Park block.
// ----------------------------------------------------------------------------
`default_nettype none

package cocp_pkg;

  // converter sample width and sine table size (table size must be a power of two)
  localparam int unsigned ADC_BITS     = 12;
  localparam int unsigned SINE_ENTRIES = 1024;
  localparam int unsigned ANGLE_BITS   = 16;
  localparam int unsigned ANGLE_DROP   = ANGLE_BITS - $clog2(SINE_ENTRIES);
  localparam logic [ANGLE_BITS-1:0] TA_MASK = ANGLE_BITS'(17'h0FFFF << ANGLE_DROP);

  localparam int unsigned OFS_FRAC  = 12;
  localparam int unsigned SUM_W     = 28;
  localparam int unsigned CNT_W     = 17;
  localparam int unsigned OFS_W     = 24;
  localparam int unsigned CAL_W     = 16;
  localparam int unsigned GAIN_W    = 24;
  localparam int unsigned PH_W      = 24;
  localparam int unsigned AB_W      = 25;
  localparam int unsigned NUM_W     = SUM_W + OFS_FRAC + 1;
  localparam int unsigned DIV_CNT_W = $clog2(NUM_W);

  localparam int unsigned IN_W     = 2 * ADC_BITS + ANGLE_BITS;
  localparam int unsigned IN_TW    = ((IN_W + 7) / 8) * 8;
  localparam int unsigned OUT_BITS = 2 * PH_W + 4 * AB_W;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_PAD  = OUT_W - OUT_BITS;

  localparam logic [CAL_W-1:0]  CAL_RESET  = 16'd10000;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd273039;

  localparam logic [15:0] POLY_A = 16'd25736;
  localparam logic [15:0] POLY_B = 16'd10512;
  localparam logic [15:0] POLY_C = 16'd1160;
  localparam logic signed [24:0] INV_SQRT3_Q24 = 25'sd9686330;

  // register indexes of the write port
  localparam logic [0:0] REG_CAL_SAMPLES  = 1'b0;
  localparam logic [0:0] REG_CURRENT_GAIN = 1'b1;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_ACC,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_DONE,
    OP_IA,
    OP_IB,
    OP_BETA,
    OP_Z2,
    OP_T1,
    OP_T2,
    OP_R,
    OP_PAC,
    OP_PBS,
    OP_PBC,
    OP_PAS,
    OP_PUSH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   cos_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic calibrated;
    logic count_lt;
    logic div_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

/* design/cocp_ctrl.sv */
// ----------------------------------------------------------------------------
// cocp_ctrl
// Sequencer: steps the datapath through calibration or one transform.
// ----------------------------------------------------------------------------
`default_nettype none

module cocp_ctrl import cocp_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  typedef enum logic [18:0] {
    S_IDLE     = 19'h00001,
    S_DISPATCH = 19'h00002,
    S_DIV      = 19'h00004,
    S_DIV_DONE = 19'h00008,
    S_IB       = 19'h00010,
    S_BETA     = 19'h00020,
    S_SZ2      = 19'h00040,
    S_ST1      = 19'h00080,
    S_ST2      = 19'h00100,
    S_SR       = 19'h00200,
    S_CZ2      = 19'h00400,
    S_CT1      = 19'h00800,
    S_CT2      = 19'h01000,
    S_CR       = 19'h02000,
    S_PAC      = 19'h04000,
    S_PBS      = 19'h08000,
    S_PBC      = 19'h10000,
    S_PAS      = 19'h20000,
    S_PUSH     = 19'h40000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    cmd_o.op      = OP_IDLE;
    cmd_o.cos_sel = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.calibrated) begin
          cmd_o.op = OP_IA;
          state_d  = S_IB;
        end else if (sts_i.count_lt) begin
          cmd_o.op = OP_ACC;
          state_d  = S_IDLE;
        end else begin
          cmd_o.op = OP_DIV_INIT;
          state_d  = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (sts_i.div_last) state_d = S_DIV_DONE;
      end
      S_DIV_DONE: begin
        cmd_o.op = OP_DIV_DONE;
        state_d  = S_IDLE;
      end
      S_IB: begin
        cmd_o.op = OP_IB;
        state_d  = S_BETA;
      end
      S_BETA: begin
        cmd_o.op = OP_BETA;
        state_d  = S_SZ2;
      end
      S_SZ2: begin
        cmd_o.op = OP_Z2;
        state_d  = S_ST1;
      end
      S_ST1: begin
        cmd_o.op = OP_T1;
        state_d  = S_ST2;
      end
      S_ST2: begin
        cmd_o.op = OP_T2;
        state_d  = S_SR;
      end
      S_SR: begin
        cmd_o.op = OP_R;
        state_d  = S_CZ2;
      end
      S_CZ2: begin
        cmd_o.op      = OP_Z2;
        cmd_o.cos_sel = 1'b1;
        state_d       = S_CT1;
      end
      S_CT1: begin
        cmd_o.op      = OP_T1;
        cmd_o.cos_sel = 1'b1;
        state_d       = S_CT2;
      end
      S_CT2: begin
        cmd_o.op      = OP_T2;
        cmd_o.cos_sel = 1'b1;
        state_d       = S_CR;
      end
      S_CR: begin
        cmd_o.op      = OP_R;
        cmd_o.cos_sel = 1'b1;
        state_d       = S_PAC;
      end
      S_PAC: begin
        cmd_o.op = OP_PAC;
        state_d  = S_PBS;
      end
      S_PBS: begin
        cmd_o.op = OP_PBS;
        state_d  = S_PBC;
      end
      S_PBC: begin
        cmd_o.op = OP_PBC;
        state_d  = S_PAS;
      end
      S_PAS: begin
        cmd_o.op = OP_PAS;
        state_d  = S_PUSH;
      end
      S_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_PUSH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* design/cocp_dp.sv */
// ----------------------------------------------------------------------------
// cocp_dp
// Datapath: offset accumulators, offset dividers, one shared multiplier for
// scaling, Clarke, sine polynomial and Park, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cocp_dp import cocp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dp_cmd_t           cmd_i,
  output dp_sts_t                sts_o,
  input  wire logic              cfg_we_i,
  input  wire logic [0:0]        cfg_idx_i,
  input  wire logic [GAIN_W-1:0] cfg_wdata_i,
  input  wire logic [IN_TW-1:0]  in_data_i,
  input  wire logic              m_axis_tready,
  output logic                   m_axis_tvalid,
  output logic [OUT_W-1:0]       m_axis_tdata
);

  function automatic logic signed [55:0] rnd(input logic signed [55:0] v, input logic [4:0] n);
    logic signed [55:0] half;
    half = 56'sd1 <<< (n - 5'd1);
    return (v + half) >>> n;
  endfunction

  function automatic logic [PH_W-1:0] sat24(input logic signed [55:0] v);
    if (v > 56'sd8388607) return 24'h7FFFFF;
    else if (v < -56'sd8388608) return 24'h800000;
    else return v[PH_W-1:0];
  endfunction

  function automatic logic [AB_W-1:0] sat25(input logic signed [55:0] v);
    if (v > 56'sd16777215) return 25'h0FFFFFF;
    else if (v < -56'sd16777216) return 25'h1000000;
    else return v[AB_W-1:0];
  endfunction

  logic [CAL_W-1:0]  cal_q;
  logic [GAIN_W-1:0] gain_q;
  logic [ADC_BITS-1:0]   a_q, b_q;
  logic [ANGLE_BITS-1:0] angle_q;
  logic [SUM_W-1:0] sum_a_q, sum_b_q;
  logic [CNT_W-1:0] cnt_q;
  logic [OFS_W-1:0] off_a_q, off_b_q;
  logic             calibrated_q;
  logic [NUM_W-1:0] num_a_q, num_b_q;
  logic [CNT_W-1:0] rem_a_q, rem_b_q;
  logic [OFS_W-1:0] quo_a_q, quo_b_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic signed [PH_W-1:0] ia_q, ib_q;
  logic signed [AB_W-1:0] beta_q, d_q, qq_q;
  logic [15:0]        z2_q, t_q;
  logic signed [16:0] sn_q, cs_q;
  logic signed [55:0] acc_q;
  logic               m_valid_q;
  logic [OUT_W-1:0]   m_data_q;

  logic signed [29:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [54:0] prod;
  logic signed [55:0] prod_x;
  logic [ANGLE_BITS-1:0] ta, p, pf;
  logic [14:0]  z;
  logic         neg;
  logic [CNT_W:0] rem_a_sh, rem_b_sh;
  logic [29:0]  r30;
  logic [16:0]  r;

  // table angle and quarter-wave fold
  always_comb begin
    ta = angle_q & TA_MASK;
    p  = cmd_i.cos_sel ? ta + 16'd16384 : ta;
    if (p >= 16'd16384 && p < 16'd49152) pf = 16'd32768 - p;
    else pf = p;
    neg = pf[15];
    z   = neg ? 15'(16'd0 - pf) : pf[14:0];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_IA: begin
        mul_a = $signed(30'({a_q, 12'b0})) - $signed(30'(off_a_q));
        mul_b = $signed(25'(gain_q));
      end
      OP_IB: begin
        mul_a = $signed(30'({b_q, 12'b0})) - $signed(30'(off_b_q));
        mul_b = $signed(25'(gain_q));
      end
      OP_BETA: begin
        mul_a = 30'(ia_q) + (30'(ib_q) <<< 1);
        mul_b = INV_SQRT3_Q24;
      end
      OP_Z2: begin
        mul_a = $signed(30'(z));
        mul_b = $signed(25'(z));
      end
      OP_T1: begin
        mul_a = $signed(30'(z2_q));
        mul_b = $signed(25'(POLY_C));
      end
      OP_T2: begin
        mul_a = $signed(30'(z2_q));
        mul_b = $signed(25'(t_q));
      end
      OP_R: begin
        mul_a = $signed(30'(z));
        mul_b = $signed(25'(t_q));
      end
      OP_PAC: begin
        mul_a = 30'(ia_q);
        mul_b = 25'(cs_q);
      end
      OP_PBS: begin
        mul_a = 30'(beta_q);
        mul_b = 25'(sn_q);
      end
      OP_PBC: begin
        mul_a = 30'(beta_q);
        mul_b = 25'(cs_q);
      end
      OP_PAS: begin
        mul_a = 30'(ia_q);
        mul_b = 25'(sn_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_x   = {prod[54], prod};
  assign r30      = prod[29:0] + 30'd4096;
  assign r        = r30[29:13];
  assign rem_a_sh = {rem_a_q, num_a_q[NUM_W-1]};
  assign rem_b_sh = {rem_b_q, num_b_q[NUM_W-1]};

  // configuration and calibration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q        <= CAL_RESET;
      gain_q       <= GAIN_RESET;
      sum_a_q      <= '0;
      sum_b_q      <= '0;
      cnt_q        <= '0;
      off_a_q      <= '0;
      off_b_q      <= '0;
      calibrated_q <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_CAL_SAMPLES:  cal_q  <= cfg_wdata_i[CAL_W-1:0];
          REG_CURRENT_GAIN: gain_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.op == OP_ACC) begin
        sum_a_q <= sum_a_q + SUM_W'(a_q);
        sum_b_q <= sum_b_q + SUM_W'(b_q);
        cnt_q   <= cnt_q + 1'b1;
      end
      if (cmd_i.op == OP_DIV_DONE) begin
        // nothing summed means zero offsets
        off_a_q      <= (cnt_q == '0) ? '0 : quo_a_q;
        off_b_q      <= (cnt_q == '0) ? '0 : quo_b_q;
        calibrated_q <= 1'b1;
      end
      if (cmd_i.op == OP_PUSH) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        a_q     <= in_data_i[ADC_BITS-1:0];
        b_q     <= in_data_i[2*ADC_BITS-1:ADC_BITS];
        angle_q <= in_data_i[IN_W-1:2*ADC_BITS];
      end
      OP_DIV_INIT: begin
        num_a_q   <= NUM_W'({sum_a_q, 12'b0}) + NUM_W'(cnt_q >> 1);
        num_b_q   <= NUM_W'({sum_b_q, 12'b0}) + NUM_W'(cnt_q >> 1);
        rem_a_q   <= '0;
        rem_b_q   <= '0;
        quo_a_q   <= '0;
        quo_b_q   <= '0;
        div_cnt_q <= '0;
      end
      OP_DIV_STEP: begin
        // restoring division, one quotient bit per lane and cycle
        num_a_q   <= num_a_q << 1;
        num_b_q   <= num_b_q << 1;
        div_cnt_q <= div_cnt_q + 1'b1;
        if (rem_a_sh >= {1'b0, cnt_q}) begin
          rem_a_q <= CNT_W'(rem_a_sh - {1'b0, cnt_q});
          quo_a_q <= {quo_a_q[OFS_W-2:0], 1'b1};
        end else begin
          rem_a_q <= rem_a_sh[CNT_W-1:0];
          quo_a_q <= {quo_a_q[OFS_W-2:0], 1'b0};
        end
        if (rem_b_sh >= {1'b0, cnt_q}) begin
          rem_b_q <= CNT_W'(rem_b_sh - {1'b0, cnt_q});
          quo_b_q <= {quo_b_q[OFS_W-2:0], 1'b1};
        end else begin
          rem_b_q <= rem_b_sh[CNT_W-1:0];
          quo_b_q <= {quo_b_q[OFS_W-2:0], 1'b0};
        end
      end
      OP_IA:   ia_q   <= sat24(rnd(prod_x, 5'd20));
      OP_IB:   ib_q   <= sat24(rnd(prod_x, 5'd20));
      OP_BETA: beta_q <= sat25(rnd(prod_x, 5'd24));
      OP_Z2:   z2_q   <= prod[29:14];
      OP_T1:   t_q    <= POLY_B - prod[29:14];
      OP_T2:   t_q    <= POLY_A - prod[29:14];
      OP_R: begin
        if (cmd_i.cos_sel) cs_q <= neg ? -$signed(r) : $signed(r);
        else sn_q <= neg ? -$signed(r) : $signed(r);
      end
      OP_PAC: acc_q <= prod_x;
      OP_PBS: d_q   <= sat25(rnd(acc_q + prod_x, 5'd15));
      OP_PBC: acc_q <= prod_x;
      OP_PAS: qq_q  <= sat25(rnd(acc_q - prod_x, 5'd15));
      OP_PUSH: begin
        m_data_q <= {{OUT_PAD{1'b0}}, qq_q, d_q, beta_q, AB_W'(ia_q), ib_q, ia_q};
      end
      default: ;
    endcase
  end

  assign sts_o.calibrated = calibrated_q;
  assign sts_o.count_lt   = cnt_q < CNT_W'(cal_q);
  assign sts_o.div_last   = div_cnt_q == DIV_CNT_W'(NUM_W - 1);
  assign sts_o.out_free   = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid    = m_valid_q;
  assign m_axis_tdata     = m_data_q;

endmodule

`default_nettype wire

/* design/current_offset_clarke_park.sv */
// ----------------------------------------------------------------------------
// current_offset_clarke_park
// Phase-current front end: offset calibration, Clarke and Park transform.
// ----------------------------------------------------------------------------
// The first cal_samples words after reset are summed per phase and give no
// output. The next word starts a restoring division of both sums and also
// gives no output. Every later word gives one output word: one shared
// multiplier is stepped through the current scaling, beta, both sine
// polynomials and the four Park products, one product per cycle. A finished
// word waits in the output register while the next input word is already
// accepted; the last step of a transform holds only while the previous
// output word is still waiting.
`default_nettype none

module current_offset_clarke_park import cocp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [0:0]        cfg_idx_i,
  input  wire logic [GAIN_W-1:0] cfg_wdata_i,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // adc_a, adc_b, elec_angle
  input  wire logic [IN_TW-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // phase_a_amps, phase_b_amps, alpha_amps, beta_amps, direct_amps,
  // quadrature_amps, zero pad
  output logic [OUT_W-1:0]       m_axis_tdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  cocp_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  cocp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_data_i     (s_axis_tdata),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

/* tb/sv/current_offset_clarke_park_test.sv */
// ----------------------------------------------------------------------------
// current_offset_clarke_park_test
// Stream test of the current offset, Clarke and Park block: an in-bench
// model tracks calibration and predicts every output word, which is checked
// field by field while both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module current_offset_clarke_park_test import cocp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_CYCLES = 80;
  localparam int unsigned STALL_LIMIT  = 5000;

  typedef struct {
    longint ph_a;
    longint ph_b;
    longint alpha;
    longint beta;
    longint d;
    longint q;
  } amps_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [0:0]        cfg_idx_i = REG_CAL_SAMPLES;
  logic [GAIN_W-1:0] cfg_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_TW-1:0]  s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;

  current_offset_clarke_park u_dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // model state
  longint unsigned cal_samples, current_gain;
  longint unsigned sum_a, sum_b, sample_cnt, offset_a, offset_b;
  bit              is_calibrated;

  amps_t           amps_q[$];
  int              error_cnt = 0;
  int              snd_idle_pct = 0;
  int              rcv_idle_pct = 0;
  int              quiet_cnt = 0;

  function automatic longint round_sat(longint v, int n, int bits);
    longint hi, lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    v = (v + (longint'(1) << (n - 1))) >>> n;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // quarter-wave folded fifth-order sine, Q1.15
  function automatic longint sine_q15(longint unsigned phase);
    longint unsigned p, z, z2, t, r;
    longint s;
    p = phase & 64'hFFFF;
    if (p >= 16384 && p < 49152) p = (32768 - p) & 64'hFFFF;
    s = (p >= 32768) ? longint'(p) - 65536 : longint'(p);
    z = (s < 0) ? -s : s;
    z2 = (z * z) >> 14;
    t = POLY_C;
    t = POLY_B - ((z2 * t) >> 14);
    t = POLY_A - ((z2 * t) >> 14);
    r = (z * t + 4096) >> 13;
    return (s < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned mean_q12(longint unsigned sum, longint unsigned cnt);
    if (cnt == 0) return 0;
    return (((sum << OFS_FRAC) + cnt / 2) / cnt) & 64'hFFFFFF;
  endfunction

  function automatic bit transform_currents(logic [IN_TW-1:0] word, output amps_t res);
    longint unsigned a_raw, b_raw, ang, k, ta;
    longint ia, ib, sn, cs;
    a_raw = word[ADC_BITS-1:0];
    b_raw = word[2*ADC_BITS-1:ADC_BITS];
    ang   = word[2*ADC_BITS+ANGLE_BITS-1:2*ADC_BITS];
    if (!is_calibrated) begin
      if (sample_cnt < cal_samples) begin
        sum_a = (sum_a + a_raw) & 64'hFFFFFFF;
        sum_b = (sum_b + b_raw) & 64'hFFFFFFF;
        sample_cnt = (sample_cnt + 1) & 64'h1FFFF;
      end else begin
        offset_a = mean_q12(sum_a, sample_cnt);
        offset_b = mean_q12(sum_b, sample_cnt);
        is_calibrated = 1'b1;
      end
      return 1'b0;
    end
    ia = (longint'(a_raw) <<< OFS_FRAC) - longint'(offset_a);
    ib = (longint'(b_raw) <<< OFS_FRAC) - longint'(offset_b);
    res.ph_a  = round_sat(ia * longint'(current_gain), 20, PH_W);
    res.ph_b  = round_sat(ib * longint'(current_gain), 20, PH_W);
    res.alpha = res.ph_a;
    res.beta  = round_sat((res.ph_a + 2 * res.ph_b) * 9686330, 24, AB_W);
    k  = (ang * SINE_ENTRIES) >> 16;
    ta = (k << 16) / SINE_ENTRIES;
    sn = sine_q15(ta);
    cs = sine_q15(ta + 16384);
    res.d = round_sat(res.alpha * cs + res.beta * sn, 15, AB_W);
    res.q = round_sat(res.beta * cs - res.alpha * sn, 15, AB_W);
    return 1'b1;
  endfunction

  task automatic write_reg(logic [0:0] idx, longint unsigned value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value[GAIN_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_CAL_SAMPLES) cal_samples = value & 64'hFFFF;
    else current_gain = value & 64'hFFFFFF;
  endtask

  task automatic send_word(longint unsigned a, longint unsigned b, longint unsigned ang);
    amps_t res;
    if ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ang[ANGLE_BITS-1:0], b[ADC_BITS-1:0], a[ADC_BITS-1:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    if (transform_currents(s_axis_tdata, res)) amps_q.push_back(res);
  endtask

  // hold off until every expected word is out and the block has gone quiet
  task automatic drain();
    @(posedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (amps_q.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(string name, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      $error("%s expected %0d actual %0d", name, exp_v, got_v);
      error_cnt++;
    end
  endtask

  // output checker and receiver stalls
  always @(posedge clk_i) begin
    amps_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (amps_q.size() == 0) begin
        $error("output word with nothing expected");
        error_cnt++;
      end else begin
        e = amps_q.pop_front();
        check_field("phase_a_amps", e.ph_a, longint'($signed(m_axis_tdata[23:0])));
        check_field("phase_b_amps", e.ph_b, longint'($signed(m_axis_tdata[47:24])));
        check_field("alpha_amps", e.alpha, longint'($signed(m_axis_tdata[72:48])));
        check_field("beta_amps", e.beta, longint'($signed(m_axis_tdata[97:73])));
        check_field("direct_amps", e.d, longint'($signed(m_axis_tdata[122:98])));
        check_field("quadrature_amps", e.q, longint'($signed(m_axis_tdata[147:123])));
      end
    end
    m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= STALL_LIMIT) begin
      $display("** current_offset_clarke_park: FAILED **");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  // calibration, with the sample count lowered part way through
  task automatic test_calibration();
    write_reg(REG_CAL_SAMPLES, 8);
    write_reg(REG_CURRENT_GAIN, GAIN_RESET);
    send_word(0, 4095, 0);
    send_word(4095, 0, 65535);
    send_word(2048, 2047, 12345);
    drain();
    write_reg(REG_CAL_SAMPLES, 2);
    send_word(1234, 3000, 999);
    drain();
  endtask

  task automatic test_directed();
    longint unsigned angles[8] = '{0, 63, 64, 16384, 32768, 49152, 65535, 40000};
    foreach (angles[i]) send_word(4095, 0, angles[i]);
    send_word(0, 4095, 8192);
    send_word(0, 0, 24576);
    send_word(4095, 4095, 57344);
    send_word(2048, 2048, 1000);
    drain();
    // count no longer matters once calibrated
    write_reg(REG_CAL_SAMPLES, 0);
    write_reg(REG_CAL_SAMPLES, 65535);
    write_reg(REG_CURRENT_GAIN, 0);
    send_word(4095, 0, 5000);
    send_word(0, 4095, 30000);
    drain();
    // full gain drives both phase currents into saturation
    write_reg(REG_CURRENT_GAIN, 24'hFFFFFF);
    send_word(4095, 4095, 8192);
    send_word(0, 0, 40960);
    send_word(4095, 0, 16384);
    send_word(0, 4095, 0);
    drain();
  endtask

  task automatic test_random(int snd_pct, int rcv_pct, int n);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    write_reg(REG_CURRENT_GAIN, ($urandom_range(3) == 0) ? $urandom_range(24'hFFFFFF)
                                                        : $urandom_range(1 << 20));
    for (int i = 0; i < n; i++) begin
      send_word($urandom_range(4095), $urandom_range(4095), $urandom_range(65535));
      if (i == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    cal_samples = CAL_RESET;
    current_gain = GAIN_RESET;
    sum_a = 0;
    sum_b = 0;
    sample_cnt = 0;
    offset_a = 0;
    offset_b = 0;
    is_calibrated = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_calibration();
    test_directed();
    test_random(16, 71, 270);
    test_random(71, 16, 270);
    test_random(0, 0, 270);
    if (error_cnt == 0) begin
      $display("** current_offset_clarke_park: PASSED **");
    end else begin
      $display("** current_offset_clarke_park: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
design/cocp_pkg.sv
design/cocp_ctrl.sv
design/cocp_dp.sv
design/current_offset_clarke_park.sv
tb/sv/current_offset_clarke_park_test.sv
